FILE: hdl/lpht_pkg.sv
// ----------------------------------------------------------------------------
// lpht_pkg: shared types and constants for the linear probe hash table
// Field widths, command and status codes, and the probe decision record
// handed from the compare unit to the sequencer.
// ----------------------------------------------------------------------------
package lpht_pkg;

	localparam int HASH_W   = 64;
	localparam int VALUE_W  = 32;
	localparam int CMD_W    = 3;
	localparam int STATUS_W = 3;
	localparam int SLOT_W   = 10;
	localparam int COUNT_W  = 11;

	localparam int          SLOTS_DEF       = 1024;
	localparam logic [10:0] MAX_ENTRIES_RST = 11'd768;

	// slot word markers
	localparam logic [HASH_W-1:0] HASH_EMPTY = 64'd0;
	localparam logic [HASH_W-1:0] HASH_TOMB  = 64'd1;

	typedef enum logic [CMD_W-1:0] {
		CMD_LOOKUP   = 3'd0,
		CMD_INSERT   = 3'd1,
		CMD_FIND_INS = 3'd2,
		CMD_REMOVE   = 3'd3,
		CMD_CLEAR    = 3'd4
	} cmd_t;

	localparam logic [STATUS_W-1:0] ST_HIT      = 3'd0;
	localparam logic [STATUS_W-1:0] ST_MISS     = 3'd1;
	localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd2;
	localparam logic [STATUS_W-1:0] ST_REMOVED  = 3'd3;
	localparam logic [STATUS_W-1:0] ST_FULL     = 3'd4;
	localparam logic [STATUS_W-1:0] ST_NOSLOT   = 3'd5;
	localparam logic [STATUS_W-1:0] ST_CLEARED  = 3'd6;

	// what to do after examining one slot
	typedef enum logic [2:0] {
		ACT_ADV    = 3'd0,
		ACT_HIT    = 3'd1,
		ACT_MISS   = 3'd2,
		ACT_STORE  = 3'd3,
		ACT_REMOVE = 3'd4,
		ACT_FULL   = 3'd5,
		ACT_NOSLOT = 3'd6
	} act_t;

	typedef struct packed {
		act_t act;
		logic use_tomb;   // store at the first tombstone seen, not the current slot
		logic mark_tomb;  // current slot is the first tombstone of this probe
	} dec_t;

endpackage

FILE: hdl/lpht_if.sv
// ----------------------------------------------------------------------------
// lpht_if: request and response channels of the hash table
// Valid/ready channels; a transfer happens when valid and ready are both high.
// ----------------------------------------------------------------------------
interface lpht_req_if import lpht_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [CMD_W-1:0]   cmd;
	logic [HASH_W-1:0]  key_hash;
	logic [VALUE_W-1:0] new_value;

	modport source (output valid, output cmd, output key_hash, output new_value,
		input ready);
	modport sink (input valid, input cmd, input key_hash, input new_value,
		output ready);
endinterface

interface lpht_rsp_if import lpht_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [SLOT_W-1:0]   slot;
	logic [VALUE_W-1:0]  value;

	modport source (output valid, output status, output slot, output value,
		input ready);
	modport sink (input valid, input status, input slot, input value,
		output ready);
endinterface

FILE: hdl/lpht_probe_dec.sv
// ----------------------------------------------------------------------------
// lpht_probe_dec: slot compare unit
// Compares one stored slot word against the key and decides whether the probe
// advances or ends, and how it ends, for the command in progress.
// ----------------------------------------------------------------------------
module lpht_probe_dec import lpht_pkg::*; (
	input  cmd_t              cmd,
	input  logic [HASH_W-1:0] slot_word,
	input  logic [HASH_W-1:0] key,
	input  logic              last,
	input  logic              full,
	input  logic              have_tomb,
	output dec_t              dec
);

	logic is_empty;
	logic is_tomb;
	logic is_match;
	act_t new_act;

	assign is_empty = (slot_word == HASH_EMPTY);
	assign is_tomb  = (slot_word == HASH_TOMB);
	assign is_match = (slot_word == key);
	assign new_act  = full ? ACT_FULL : ACT_STORE;

	// decide on the current slot
	always_comb begin
		dec.act       = ACT_MISS;
		dec.use_tomb  = 1'b0;
		dec.mark_tomb = 1'b0;
		case (cmd)
			CMD_LOOKUP, CMD_REMOVE: begin
				if (is_empty) begin
					dec.act = ACT_MISS;
				end else if (is_match) begin
					dec.act = (cmd == CMD_REMOVE) ? ACT_REMOVE : ACT_HIT;
				end else if (last) begin
					dec.act = ACT_MISS;
				end else begin
					dec.act = ACT_ADV;
				end
			end
			CMD_INSERT: begin
				if (full) begin
					dec.act = ACT_FULL;
				end else if (is_empty || is_tomb) begin
					dec.act = ACT_STORE;
				end else if (last) begin
					dec.act = ACT_NOSLOT;
				end else begin
					dec.act = ACT_ADV;
				end
			end
			CMD_FIND_INS: begin
				if (is_empty) begin
					dec.act      = new_act;
					dec.use_tomb = have_tomb;
				end else if (is_tomb) begin
					dec.mark_tomb = !have_tomb;
					dec.use_tomb  = have_tomb;
					dec.act       = last ? new_act : ACT_ADV;
				end else if (is_match) begin
					dec.act = ACT_HIT;
				end else if (last) begin
					dec.act      = have_tomb ? new_act : ACT_NOSLOT;
					dec.use_tomb = have_tomb;
				end else begin
					dec.act = ACT_ADV;
				end
			end
			default: begin
				dec.act = ACT_MISS;
			end
		endcase
	end

endmodule

FILE: hdl/linear_probe_hash_table_top.sv
// ----------------------------------------------------------------------------
// linear_probe_hash_table_top: open addressing hash table, linear probing
// Slot table keyed by a precomputed 64-bit hash, with lookup, insert,
// find-or-insert, remove and clear commands.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one command (cmd, key_hash, new_value) per transfer; rsp
//   returns exactly one result (status, slot, value) per command, in order.
//   cfg_we/cfg_wdata write max_entries (reset 768); write only when idle.
//   The table is a slot memory with one read and one write port, examined by
//   one compare unit, one slot per cycle. A command is taken in S_IDLE, probes
//   its slots in S_PROBE and passes its result through S_EMIT into the output
//   register; the next command is taken once the sequencer is back in S_IDLE.
//   Clear sweeps every slot in S_WIPE before S_EMIT; unknown commands go
//   straight to S_EMIT. After reset the same sweep empties the table in
//   S_INIT, and req.ready stays low until it ends. The result sits in an
//   output register, so a stalled receiver does not stop the next command
//   from being taken and processed; it is held only at the point where its
//   own result would be loaded.
// ----------------------------------------------------------------------------
module linear_probe_hash_table_top import lpht_pkg::*; #(
	parameter int SLOTS = SLOTS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [COUNT_W-1:0] cfg_wdata,
	lpht_req_if.sink           req,
	lpht_rsp_if.source         rsp
);

	localparam int IDX_W = $clog2(SLOTS);

	typedef enum logic [4:0] {
		S_INIT  = 5'b00001,
		S_IDLE  = 5'b00010,
		S_PROBE = 5'b00100,
		S_WIPE  = 5'b01000,
		S_EMIT  = 5'b10000
	} state_t;

	state_t               state_q;
	cmd_t                 cmd_q;
	logic [HASH_W-1:0]    key_q;
	logic [VALUE_W-1:0]   val_q;
	logic [IDX_W-1:0]     pos_q;
	logic [IDX_W-1:0]     cnt_q;
	logic [IDX_W-1:0]     tomb_q;
	logic                 have_tomb_q;
	logic [COUNT_W-1:0]   live_q;
	logic [COUNT_W-1:0]   max_q;
	logic [STATUS_W-1:0]  res_status_q;
	logic [SLOT_W-1:0]    res_slot_q;
	logic [VALUE_W-1:0]   res_value_q;
	logic                 rsp_valid_q;
	logic [STATUS_W-1:0]  rsp_status_q;
	logic [SLOT_W-1:0]    rsp_slot_q;
	logic [VALUE_W-1:0]   rsp_value_q;

	logic [HASH_W-1:0]    hash_mem [SLOTS];
	logic [VALUE_W-1:0]   value_mem [SLOTS];
	logic [HASH_W-1:0]    hash_rd_q;
	logic [VALUE_W-1:0]   value_rd_q;

	logic [HASH_W-1:0]    in_key;
	logic [IDX_W-1:0]     rd_addr;
	logic [IDX_W-1:0]     store_idx;
	logic                 hash_we;
	logic [IDX_W-1:0]     hash_waddr;
	logic [HASH_W-1:0]    hash_wdata;
	logic                 value_we;
	logic                 accept;
	logic                 out_free;
	logic                 full;
	dec_t                 dec;

	// fit a slot index onto the fixed-width slot field
	function automatic logic [SLOT_W-1:0] to_slot(logic [IDX_W-1:0] idx);
		logic [SLOT_W+IDX_W-1:0] wide;
		wide = {{SLOT_W{1'b0}}, idx};
		return wide[SLOT_W-1:0];
	endfunction

	// raise the reserved hashes out of the empty and tombstone codes
	assign in_key = (req.key_hash[HASH_W-1:1] == '0) ? req.key_hash + HASH_W'(2)
		: req.key_hash;

	assign req.ready  = (state_q == S_IDLE);
	assign accept     = req.valid && req.ready;
	assign out_free   = !rsp_valid_q || rsp.ready;
	assign full       = (live_q >= max_q);
	assign store_idx  = dec.use_tomb ? tomb_q : pos_q;

	assign rsp.valid  = rsp_valid_q;
	assign rsp.status = rsp_status_q;
	assign rsp.slot   = rsp_slot_q;
	assign rsp.value  = rsp_value_q;

	lpht_probe_dec u_dec (
		.cmd       (cmd_q),
		.slot_word (hash_rd_q),
		.key       (key_q),
		.last      (&cnt_q),
		.full      (full),
		.have_tomb (have_tomb_q),
		.dec       (dec)
	);

	// select the slot read next: home slot while idle, the next slot when the probe advances, else the probe position
	always_comb begin
		rd_addr = pos_q;
		if (state_q == S_IDLE) begin
			rd_addr = in_key[IDX_W-1:0];
		end else if (state_q == S_PROBE && dec.act == ACT_ADV) begin
			rd_addr = pos_q + IDX_W'(1);
		end
	end

	// slot writes: sweep to empty, new entries, tombstones
	always_comb begin
		hash_we    = 1'b0;
		hash_waddr = pos_q;
		hash_wdata = HASH_EMPTY;
		value_we   = 1'b0;
		case (state_q)
			S_INIT, S_WIPE: begin
				hash_we = 1'b1;
			end
			S_PROBE: begin
				if (dec.act == ACT_STORE) begin
					hash_we    = 1'b1;
					hash_waddr = store_idx;
					hash_wdata = key_q;
					value_we   = 1'b1;
				end else if (dec.act == ACT_REMOVE) begin
					hash_we    = 1'b1;
					hash_wdata = HASH_TOMB;
				end
			end
			default: begin
				hash_we = 1'b0;
			end
		endcase
	end

	// slot memories, registered read
	always_ff @(posedge clk) begin
		if (hash_we) begin
			hash_mem[hash_waddr] <= hash_wdata;
		end
		hash_rd_q <= hash_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (value_we) begin
			value_mem[store_idx] <= val_q;
		end
		value_rd_q <= value_mem[rd_addr];
	end

	// hold the limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q <= MAX_ENTRIES_RST;
		end else if (cfg_we) begin
			max_q <= cfg_wdata;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			pos_q       <= '0;
			cnt_q       <= '0;
			have_tomb_q <= 1'b0;
			live_q      <= '0;
		end else begin
			case (state_q)
				S_INIT: begin
					pos_q <= pos_q + IDX_W'(1);
					if (&pos_q) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						cnt_q       <= '0;
						have_tomb_q <= 1'b0;
						if (cmd_t'(req.cmd) == CMD_CLEAR) begin
							pos_q   <= '0;
							live_q  <= '0;
							state_q <= S_WIPE;
						end else if (req.cmd > CMD_CLEAR) begin
							state_q <= S_EMIT;
						end else begin
							pos_q   <= in_key[IDX_W-1:0];
							state_q <= S_PROBE;
						end
					end
				end
				S_PROBE: begin
					if (dec.mark_tomb) begin
						have_tomb_q <= 1'b1;
					end
					if (dec.act == ACT_ADV) begin
						pos_q <= pos_q + IDX_W'(1);
						cnt_q <= cnt_q + IDX_W'(1);
					end else begin
						state_q <= S_EMIT;
						if (dec.act == ACT_STORE) begin
							live_q <= live_q + COUNT_W'(1);
						end else if (dec.act == ACT_REMOVE && live_q != '0) begin
							live_q <= live_q - COUNT_W'(1);
						end
					end
				end
				S_WIPE: begin
					pos_q <= pos_q + IDX_W'(1);
					if (&pos_q) begin
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_INIT;
				end
			endcase
		end
	end

	// capture the command and build the pending result
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q        <= cmd_t'(req.cmd);
			key_q        <= in_key;
			val_q        <= req.new_value;
			res_status_q <= (cmd_t'(req.cmd) == CMD_CLEAR) ? ST_CLEARED : ST_MISS;
			res_slot_q   <= '0;
			res_value_q  <= '0;
		end
		if (state_q == S_PROBE) begin
			if (dec.mark_tomb) begin
				tomb_q <= pos_q;
			end
			case (dec.act)
				ACT_HIT: begin
					res_status_q <= ST_HIT;
					res_slot_q   <= to_slot(pos_q);
					res_value_q  <= value_rd_q;
				end
				ACT_REMOVE: begin
					res_status_q <= ST_REMOVED;
					res_slot_q   <= to_slot(pos_q);
					res_value_q  <= value_rd_q;
				end
				ACT_STORE: begin
					res_status_q <= ST_INSERTED;
					res_slot_q   <= to_slot(store_idx);
					res_value_q  <= val_q;
				end
				ACT_FULL: begin
					res_status_q <= ST_FULL;
				end
				ACT_NOSLOT: begin
					res_status_q <= ST_NOSLOT;
				end
				default: begin
					res_status_q <= ST_MISS;
				end
			endcase
		end
	end

	// output register: load when free, drop on transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (state_q == S_EMIT && out_free) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_EMIT && out_free) begin
			rsp_status_q <= res_status_q;
			rsp_slot_q   <= res_slot_q;
			rsp_value_q  <= res_value_q;
		end
	end

`ifndef SYNTHESIS
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !req.ready)
		else $error("request taken while a command is in progress");

	a_store_room: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PROBE && dec.act == ACT_STORE) |-> (live_q < max_q))
		else $error("entry stored beyond the live entry limit");

	a_clear_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT && res_status_q == ST_CLEARED) |-> (live_q == '0))
		else $error("live count not zero after clear");

	a_rsp_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q == S_EMIT))
		else $error("result raised outside the emit step");
`endif

endmodule
